[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the tag table top level.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/dmtt_pkg.sv]
// Package of the direct-mapped tag table: command codes and default sizes.
// No dependencies.
package dmtt_pkg;

  localparam int unsigned HashWidth      = 64;
  localparam int unsigned CmdWidth       = 2;
  localparam int unsigned FlagIdxWidth   = 2;

  localparam int unsigned DefIndexBits   = 16;
  localparam int unsigned DefFlagBits    = 4;
  localparam int unsigned DefHashBits    = 64;

  typedef enum logic [CmdWidth-1:0] {
    CmdProbe     = 2'd0,
    CmdSetValid  = 2'd1,
    CmdReadFlag  = 2'd2,
    CmdWriteFlag = 2'd3
  } dmtt_cmd_e;

endpackage

[rtl/core/dmtt_if.sv]
// Request and response channel interfaces of the tag table.
// Depends on dmtt_pkg.
interface dmtt_req_if;
  logic                                valid;
  logic                                ready;
  logic [dmtt_pkg::CmdWidth-1:0]       command;
  logic [dmtt_pkg::HashWidth-1:0]      hash;
  logic [dmtt_pkg::FlagIdxWidth-1:0]   flag_index;
  logic                                bit_value;

  modport source (output valid, command, hash, flag_index, bit_value, input ready);
  modport sink   (input valid, command, hash, flag_index, bit_value, output ready);
endinterface

interface dmtt_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic flag_out;
  logic fault;

  modport source (output valid, hit, flag_out, fault, input ready);
  modport sink   (input valid, hit, flag_out, fault, output ready);
endinterface

[rtl/core/direct_mapped_tag_table.sv]
// Direct-mapped tag table top level: entry RAM, clearing pass, lookup and update.
// Depends on dmtt_pkg, dmtt_if, dmtt_ram and assert_macros.svh.
//
//  channel | dir | payload                                 | transfer when
//  --------+-----+-----------------------------------------+--------------------
//  req_i   | in  | command, hash, flag_index, bit_value     | valid && ready
//  rsp_o   | out | hit, flag_out, fault                     | valid && ready
//
// After reset a clearing pass writes zero to all 2**INDEX_BITS entries, one per
// cycle; req_i.ready stays low meanwhile. The transfer cycle of an item issues
// the RAM read, the next one evaluates the entry, writes it back and loads the
// response register. The read-modify-write on the entry RAM means no new
// request is taken while an item is still in lookup. A response waiting in
// rsp_o stalls only the next lookup: a new request is taken once the response
// register is free or is being drained that cycle.
`include "assert_macros.svh"

module direct_mapped_tag_table #(
  parameter int unsigned INDEX_BITS = dmtt_pkg::DefIndexBits,
  parameter int unsigned FLAG_BITS  = dmtt_pkg::DefFlagBits,
  parameter int unsigned HASH_BITS  = dmtt_pkg::DefHashBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmtt_req_if.sink    req_i,
  dmtt_rsp_if.source  rsp_o
);

  localparam int unsigned TagBits  = HASH_BITS - INDEX_BITS;
  localparam int unsigned WordBits = 1 + TagBits + FLAG_BITS;
  localparam int unsigned Depth    = 2 ** INDEX_BITS;

  // sequencer states
  localparam logic StClear = 1'b0;
  localparam logic StRun   = 1'b1;

  logic                  state_q, state_d;
  logic [INDEX_BITS-1:0] clr_cnt_q, clr_cnt_d;

  // item in lookup
  logic                  pend_q;
  dmtt_pkg::dmtt_cmd_e   cmd_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [TagBits-1:0]    tag_q;
  logic [dmtt_pkg::FlagIdxWidth-1:0] fidx_q;
  logic                  val_q;

  // response register
  logic rsp_valid_q, rsp_hit_q, rsp_flag_q, rsp_fault_q;

  logic                  req_xfer;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [WordBits-1:0]   wr_data;
  logic [WordBits-1:0]   rd_data;

  logic                  ent_valid;
  logic [TagBits-1:0]    ent_tag;
  logic [FLAG_BITS-1:0]  ent_flags;
  logic [FLAG_BITS-1:0]  flag_sel;
  logic [FLAG_BITS-1:0]  new_flags;
  logic                  lk_hit;
  logic                  lk_flag;
  logic                  lk_fault;
  logic                  lk_write;
  logic [WordBits-1:0]   lk_word;

  // only one item in flight, and only when its response slot is certain to be free
  assign req_i.ready = (state_q == StRun) && !pend_q && (!rsp_valid_q || rsp_o.ready);
  assign req_xfer    = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Clearing pass sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      StClear: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = StRun;
        end
      end
      StRun: begin
        clr_cnt_d = clr_cnt_q;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture: the RAM read is issued in the same cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= req_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      cmd_q  <= dmtt_pkg::dmtt_cmd_e'(req_i.command);
      idx_q  <= req_i.hash[INDEX_BITS-1:0];
      tag_q  <= req_i.hash[HASH_BITS-1:INDEX_BITS];
      fidx_q <= req_i.flag_index;
      val_q  <= req_i.bit_value;
    end
  end

  dmtt_ram #(
    .WIDTH (WordBits),
    .DEPTH (Depth)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (req_xfer),
    .rd_addr_i (req_i.hash[INDEX_BITS-1:0]),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Lookup and modify. Entry word layout: {valid, tag, flags}.
  // ---------------------------------------------------------------------------
  assign ent_valid = rd_data[WordBits-1];
  assign ent_tag   = rd_data[FLAG_BITS +: TagBits];
  assign ent_flags = rd_data[FLAG_BITS-1:0];

  // flag indexes of FLAG_BITS or more select nothing: read as zero, write ignored
  always_comb begin
    for (int e = 0; e < int'(FLAG_BITS); e++) begin
      flag_sel[e] = (int'(fidx_q) == e);
    end
  end

  assign new_flags = (ent_flags & ~flag_sel) | (val_q ? flag_sel : '0);
  assign lk_hit    = ent_valid && (ent_tag == tag_q);

  always_comb begin
    lk_flag  = 1'b0;
    lk_fault = 1'b0;
    lk_write = 1'b0;
    lk_word  = rd_data;
    case (cmd_q)
      dmtt_pkg::CmdProbe: begin
        lk_write = 1'b0;
      end
      dmtt_pkg::CmdSetValid: begin
        // invalidate stores a zero tag; flags are kept
        lk_write = 1'b1;
        lk_word  = {val_q, (val_q ? tag_q : {TagBits{1'b0}}), ent_flags};
      end
      dmtt_pkg::CmdReadFlag: begin
        lk_fault = !lk_hit;
        lk_flag  = lk_hit && |(ent_flags & flag_sel);
      end
      dmtt_pkg::CmdWriteFlag: begin
        lk_fault = !lk_hit;
        lk_write = lk_hit;
        lk_word  = {ent_valid, ent_tag, new_flags};
      end
      default: begin
        lk_write = 1'b0;
      end
    endcase
  end

  // write port: clearing pass owns it until the table is ready
  assign wr_en   = (state_q == StClear) || (pend_q && lk_write);
  assign wr_addr = (state_q == StClear) ? clr_cnt_q : idx_q;
  assign wr_data = (state_q == StClear) ? '0 : lk_word;

  // ---------------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (pend_q) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      rsp_hit_q   <= lk_hit;
      rsp_flag_q  <= lk_flag;
      rsp_fault_q <= lk_fault;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.hit      = rsp_hit_q;
  assign rsp_o.flag_out = rsp_flag_q;
  assign rsp_o.fault    = rsp_fault_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a lookup never lands on a response still waiting to be taken
  `ASSERT_NEVER(a_pend_slot_free, clk_i, rst_ni, pend_q && rsp_valid_q)
  // every lookup shows up as a response in the next cycle
  `ASSERT_PROP(a_pend_to_rsp, clk_i, rst_ni, pend_q |=> rsp_o.valid)
  // no item is looked up while the clearing pass still owns the RAM
  `ASSERT_NEVER(a_no_pend_in_clear, clk_i, rst_ni, pend_q && (state_q == StClear))
  // a fault and a read flag value never come together
  `ASSERT_NEVER(a_fault_no_flag, clk_i, rst_ni, rsp_o.valid && rsp_o.fault && rsp_o.flag_out)

endmodule

[rtl/core/dmtt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dmtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
